// ----- rtl/dpmc_pkg.sv -----
// Package for the delay playhead mode controller.
// Holds the mode encoding, configuration register indexes, fixed constants and
// the wide playhead type. No dependencies.
`default_nettype none

package dpmc_pkg;

  typedef enum logic [2:0] {
    MODE_LIVE    = 3'd0,
    MODE_DELAYED = 3'd1,
    MODE_PAUSED  = 3'd2,
    MODE_ACCEL   = 3'd3,
    MODE_DECEL   = 3'd4,
    MODE_PLAY    = 3'd5
  } mode_t;

  localparam logic [2:0] CFG_ENABLE       = 3'd0;
  localparam logic [2:0] CFG_TARGET_DELAY = 3'd1;
  localparam logic [2:0] CFG_MIN_LIVE     = 3'd2;
  localparam logic [2:0] CFG_ACCEL_SPEED  = 3'd3;
  localparam logic [2:0] CFG_DECEL_SPEED  = 3'd4;
  localparam logic [2:0] CFG_PLAY_SPEED   = 3'd5;

  localparam logic [15:0] SPEED_ONE        = 16'd256;
  localparam logic [15:0] ACCEL_SPEED_RST  = 16'd512;
  localparam logic [15:0] DECEL_SPEED_RST  = 16'd128;
  localparam logic [39:0] NO_DEPTH_SPAN_NS = 40'd600000000000;
  localparam logic [39:0] DIST_MAX         = 40'hFF_FFFF_FFFF;
  localparam logic [40:0] SNAP_FREE        = 41'h1FF_FFFF_FFFF;

  // Wide signed type for playhead arithmetic: holds now plus any seek and step.
  typedef logic signed [65:0] ph_t;

endpackage

`default_nettype wire

// ----- rtl/delay_playhead_mode_controller_unit.sv -----
// Top level of the delay playhead mode controller: input register, playhead and
// mode update logic, result register. Depends on dpmc_pkg.
//
//   Channel  Direction  Handshake              Carries
//   in_*     input      in_valid / in_ready    one tick: time, seek, depth, commands
//   out_*    output     out_valid / out_ready  playhead, audio speed, snap, mode
//   cfg_*    input      cfg_write_en           register index and write data
//
// One transaction is accepted per cycle unless the output stalls; each result passes
// through the input register, which holds the products and per-tick bounds, and the
// result register, which holds the clamped playhead. The state updates as a
// transaction leaves the input register. A stalled output holds the input register,
// which then fills and lowers in_ready. Reset is synchronous; while disabled,
// transactions are taken and dropped.
`default_nettype none

module delay_playhead_mode_controller_unit
  import dpmc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [62:0] in_now_ns,
  input  wire logic        [31:0] in_elapsed_ns,
  input  wire logic signed [40:0] in_seek_ns,
  input  wire logic        [39:0] in_buffered_ns,
  input  wire logic               in_mode_write,
  input  wire logic        [2:0]  in_new_mode,
  input  wire logic               in_distance_write,
  input  wire logic        [39:0] in_start_distance_ns,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [62:0] out_frame_pos_ns,
  output logic             [15:0] out_snd_rate,
  output logic signed      [40:0] out_snd_lag_ns,
  output logic             [2:0]  out_mode_out,
  input  wire logic               cfg_write_en,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [39:0] cfg_wdata
);

  logic        cfg_enable_r;
  logic [39:0] cfg_target_delay_r;
  logic [29:0] cfg_min_live_r;
  logic [15:0] cfg_accel_speed_r;
  logic [15:0] cfg_decel_speed_r;
  logic [15:0] cfg_play_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enable_r       <= 1'b0;
      cfg_target_delay_r <= '0;
      cfg_min_live_r     <= '0;
      cfg_accel_speed_r  <= ACCEL_SPEED_RST;
      cfg_decel_speed_r  <= DECEL_SPEED_RST;
      cfg_play_speed_r   <= SPEED_ONE;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ENABLE:       cfg_enable_r       <= cfg_wdata[0];
        CFG_TARGET_DELAY: cfg_target_delay_r <= cfg_wdata;
        CFG_MIN_LIVE:     cfg_min_live_r     <= cfg_wdata[29:0];
        CFG_ACCEL_SPEED:  cfg_accel_speed_r  <= cfg_wdata[15:0];
        CFG_DECEL_SPEED:  cfg_decel_speed_r  <= cfg_wdata[15:0];
        CFG_PLAY_SPEED:   cfg_play_speed_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input stage.
  logic        s1_valid_r;
  logic        s1_adv;
  logic        in_take;
  logic [62:0] s1_now_r;
  logic signed [40:0] s1_seek_r;
  logic [39:0] s1_step_acc_r;
  logic [39:0] s1_step_dec_r;
  logic [39:0] s1_play_delta_r;
  logic        s1_play_sub_r;
  logic        s1_mode_ld_r;
  mode_t       s1_mode_val_r;
  logic        s1_dist_ld_r;
  logic [39:0] s1_dist_val_r;
  logic [39:0] s1_eff_r;
  logic [39:0] s1_span_r;

  logic [47:0] prod_acc;
  logic [47:0] prod_dec;
  logic [47:0] prod_play;
  logic [15:0] play_diff;
  logic        play_sub;
  logic [39:0] eff_nxt;
  logic [39:0] span_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  assign play_sub  = cfg_play_speed_r > SPEED_ONE;
  assign play_diff = play_sub ? (cfg_play_speed_r - SPEED_ONE)
                              : (SPEED_ONE - cfg_play_speed_r);
  assign prod_acc  = in_elapsed_ns * cfg_accel_speed_r;
  assign prod_dec  = in_elapsed_ns * cfg_decel_speed_r;
  assign prod_play = in_elapsed_ns * play_diff;
  assign eff_nxt   = (in_buffered_ns != '0 && cfg_target_delay_r > in_buffered_ns)
                     ? in_buffered_ns : cfg_target_delay_r;
  assign span_nxt  = (in_buffered_ns != '0) ? in_buffered_ns : NO_DEPTH_SPAN_NS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= cfg_enable_r;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r        <= in_now_ns;
      s1_seek_r       <= in_seek_ns;
      s1_step_acc_r   <= prod_acc[47:8];
      s1_step_dec_r   <= prod_dec[47:8];
      s1_play_delta_r <= prod_play[47:8];
      s1_play_sub_r   <= play_sub;
      s1_mode_ld_r    <= in_mode_write && (in_new_mode <= MODE_PLAY);
      s1_mode_val_r   <= mode_t'(in_new_mode);
      s1_dist_ld_r    <= in_distance_write;
      s1_dist_val_r   <= in_start_distance_ns;
      s1_eff_r        <= eff_nxt;
      s1_span_r       <= span_nxt;
    end
  end

  // Controller state.
  mode_t       mode_r;
  mode_t       mode_nxt;
  mode_t       mode_cur;
  logic        init_r;
  logic [62:0] playhead_r;
  logic [39:0] play_distance_r;
  logic [39:0] dist_nxt;

  ph_t now_s;
  ph_t tdel_s;
  ph_t minl_s;
  ph_t eff_s;
  ph_t tph;
  ph_t base;
  ph_t ph_seek;
  ph_t acc_ph;
  ph_t dec_ph;
  ph_t ph_play;
  ph_t ph_sel;
  ph_t floor_s;
  ph_t ph_c1;
  ph_t ph_c2;
  ph_t ph_fin;
  logic pause_done;
  logic acc_done;
  logic dec_done;

  logic [39:0]        d0;
  logic signed [41:0] d_sum;
  logic [39:0]        d_clamp;

  logic [15:0]        spd;
  logic [40:0]        snap;

  assign mode_cur = s1_mode_ld_r ? s1_mode_val_r : mode_r;

  assign now_s  = $signed({3'b000, s1_now_r});
  assign tdel_s = $signed({26'd0, cfg_target_delay_r});
  assign minl_s = $signed({36'd0, cfg_min_live_r});
  assign eff_s  = $signed({26'd0, s1_eff_r});
  assign tph    = now_s - eff_s;

  assign base    = init_r ? $signed({3'b000, playhead_r}) : (now_s - tdel_s);
  assign ph_seek = base + $signed({{25{s1_seek_r[40]}}, s1_seek_r});

  assign pause_done = (s1_eff_r != '0) && (ph_seek <= tph);
  assign acc_ph     = (ph_seek < now_s) ? (ph_seek + $signed({26'd0, s1_step_acc_r}))
                                        : ph_seek;
  assign acc_done   = acc_ph >= now_s;
  assign dec_ph     = (ph_seek > tph) ? (ph_seek + $signed({26'd0, s1_step_dec_r}))
                                      : ph_seek;
  assign dec_done   = dec_ph <= tph;

  assign d0    = s1_dist_ld_r ? s1_dist_val_r : play_distance_r;
  assign d_sum = s1_play_sub_r ? ($signed({2'b00, d0}) - $signed({2'b00, s1_play_delta_r}))
                               : ($signed({2'b00, d0}) + $signed({2'b00, s1_play_delta_r}));

  always_comb begin
    if (d_sum < $signed({12'd0, cfg_min_live_r})) begin
      d_clamp = {10'd0, cfg_min_live_r};
    end else if (d_sum > $signed({2'b00, DIST_MAX})) begin
      d_clamp = DIST_MAX;
    end else begin
      d_clamp = d_sum[39:0];
    end
  end

  assign ph_play  = now_s - $signed({26'd0, d_clamp});
  assign dist_nxt = (mode_cur == MODE_PLAY) ? d_clamp : d0;

  // Next mode.
  always_comb begin
    mode_nxt = mode_cur;
    unique case (mode_cur)
      MODE_LIVE:    mode_nxt = MODE_LIVE;
      MODE_DELAYED: mode_nxt = MODE_DELAYED;
      MODE_PAUSED:  mode_nxt = pause_done ? MODE_DELAYED : MODE_PAUSED;
      MODE_ACCEL:   mode_nxt = acc_done ? MODE_LIVE : MODE_ACCEL;
      MODE_DECEL:   mode_nxt = dec_done ? MODE_DELAYED : MODE_DECEL;
      MODE_PLAY:    mode_nxt = MODE_PLAY;
      default:      mode_nxt = mode_cur;
    endcase
  end

  // Playhead before clamping, audio speed and audio snap.
  always_comb begin
    ph_sel = ph_seek;
    spd    = SPEED_ONE;
    snap   = SNAP_FREE;
    unique case (mode_cur)
      MODE_LIVE: begin
        ph_sel = now_s - minl_s;
        snap   = {11'd0, cfg_min_live_r};
      end
      MODE_DELAYED: begin
        ph_sel = now_s - tdel_s;
        snap   = {1'b0, cfg_target_delay_r};
      end
      MODE_PAUSED: begin
        if (pause_done) begin
          ph_sel = tph;
          snap   = {1'b0, s1_eff_r};
        end else begin
          ph_sel = ph_seek;
          spd    = '0;
        end
      end
      MODE_ACCEL: begin
        if (acc_done) begin
          ph_sel = now_s;
          snap   = {11'd0, cfg_min_live_r};
        end else begin
          ph_sel = acc_ph;
          spd    = cfg_accel_speed_r;
        end
      end
      MODE_DECEL: begin
        if (dec_done) begin
          ph_sel = tph;
          snap   = {1'b0, s1_eff_r};
        end else begin
          ph_sel = dec_ph;
          spd    = cfg_decel_speed_r;
        end
      end
      MODE_PLAY: begin
        ph_sel = ph_play;
        spd    = cfg_play_speed_r;
      end
      default: begin
        ph_sel = ph_seek;
      end
    endcase
  end

  // Clamp between now minus the depth (or a fixed span) and now, and never below zero.
  assign floor_s = now_s - $signed({26'd0, s1_span_r});
  assign ph_c1   = (ph_sel > now_s) ? now_s : ph_sel;
  assign ph_c2   = (ph_c1 < floor_s) ? floor_s : ph_c1;
  assign ph_fin  = (ph_c2 < 0) ? '0 : ph_c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_LIVE;
      init_r          <= 1'b0;
      playhead_r      <= '0;
      play_distance_r <= '0;
    end else if (s1_adv) begin
      mode_r          <= mode_nxt;
      init_r          <= 1'b1;
      playhead_r      <= ph_fin[62:0];
      play_distance_r <= dist_nxt;
    end
  end

  // Result register.
  logic        out_valid_r;
  logic [62:0] out_playhead_r;
  logic [15:0] out_speed_r;
  logic [40:0] out_snap_r;
  mode_t       out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_playhead_r <= ph_fin[62:0];
      out_speed_r    <= spd;
      out_snap_r     <= snap;
      out_mode_r     <= mode_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_pos_ns = out_playhead_r;
  assign out_snd_rate     = out_speed_r;
  assign out_snd_lag_ns   = $signed(out_snap_r);
  assign out_mode_out     = out_mode_r;

endmodule

`default_nettype wire

// ----- test/tb_delay_playhead_mode_controller_unit.sv -----
// Self-checking testbench for delay_playhead_mode_controller_unit: directed and random
// ticks under random idling on both channels, checked against a playhead predictor.
// Depends on dpmc_pkg and the unit under test.
`timescale 1ns / 100ps

module tb_delay_playhead_mode_controller_unit;
  import dpmc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam longint LMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint LMIN = 64'h8000_0000_0000_0000;
  localparam longint SEC = 64'd1_000_000_000;
  localparam longint MSEC = 64'd1_000_000;
  localparam logic [62:0] NOW_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [40:0] SEEK_MAX = 41'h0FF_FFFF_FFFF;
  localparam logic signed [40:0] SEEK_MIN = 41'h100_0000_0000;

  typedef struct packed {
    logic [62:0]        now;
    logic [31:0]        elapsed;
    logic signed [40:0] seek;
    logic [39:0]        buffered;
    logic               mode_write;
    logic [2:0]         new_mode;
    logic               distance_write;
    logic [39:0]        start_dist;
  } tick_t;

  typedef struct packed {
    logic [62:0]        playhead;
    logic [15:0]        speed;
    logic signed [40:0] snap;
    logic [2:0]         mode;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [62:0] in_now_ns = '0;
  logic [31:0] in_elapsed_ns = '0;
  logic signed [40:0] in_seek_ns = '0;
  logic [39:0] in_buffered_ns = '0;
  logic in_mode_write = 1'b0;
  logic [2:0] in_new_mode = '0;
  logic in_distance_write = 1'b0;
  logic [39:0] in_start_distance_ns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [62:0] out_frame_pos_ns;
  logic [15:0] out_snd_rate;
  logic signed [40:0] out_snd_lag_ns;
  logic [2:0] out_mode_out;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [39:0] cfg_wdata = '0;

  delay_playhead_mode_controller_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_now_ns(in_now_ns),
    .in_elapsed_ns(in_elapsed_ns),
    .in_seek_ns(in_seek_ns),
    .in_buffered_ns(in_buffered_ns),
    .in_mode_write(in_mode_write),
    .in_new_mode(in_new_mode),
    .in_distance_write(in_distance_write),
    .in_start_distance_ns(in_start_distance_ns),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_pos_ns(out_frame_pos_ns),
    .out_snd_rate(out_snd_rate),
    .out_snd_lag_ns(out_snd_lag_ns),
    .out_mode_out(out_mode_out),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the configuration and of the playhead state.
  logic        cf_enable = 1'b0;
  longint      cf_delay = 0;
  longint      cf_minlive = 0;
  logic [15:0] cf_accel = ACCEL_SPEED_RST;
  logic [15:0] cf_decel = DECEL_SPEED_RST;
  logic [15:0] cf_play = SPEED_ONE;
  longint      ph_state = 0;
  mode_t       mode_state = MODE_LIVE;
  logic        ph_started = 1'b0;
  longint      dist_state = 0;

  tick_t  pending_ticks[$];
  frame_t expected_frames[$];
  tick_t  drive_tick;
  frame_t exp_f;
  logic   in_fire = 1'b0;
  longint gen_now = 64'd5_000_000_000_000;
  int     fails = 0;
  int     ticks_taken = 0;
  int     ticks_dropped = 0;
  int     results_seen = 0;
  int     settings_used = 0;
  int     cycles = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  int     mode_hits[6] = '{default: 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > LMAX - b) return LMAX;
    if (b < 0 && a < LMIN - b) return LMIN;
    return a + b;
  endfunction

  function automatic void predict_frame(tick_t t);
    longint now, sk, depth, ph, eff, snap, d, tph, oldest, advance, dist_cap;
    logic [15:0] spd;
    frame_t f;
    if (!cf_enable) begin
      ticks_dropped++;
      return;
    end
    now = longint'({1'b0, t.now});
    sk = {{23{t.seek[40]}}, t.seek};
    depth = longint'({24'd0, t.buffered});
    dist_cap = longint'({24'd0, DIST_MAX});
    if (t.mode_write && t.new_mode <= MODE_PLAY) mode_state = mode_t'(t.new_mode);
    if (t.distance_write) dist_state = longint'({24'd0, t.start_dist});
    ph = ph_state;
    if (!ph_started) begin
      ph = now - cf_delay;
      ph_started = 1'b1;
    end
    ph = sat_sum(ph, sk);
    spd = SPEED_ONE;
    snap = -1;
    eff = cf_delay;
    if (depth > 0 && eff > depth) eff = depth;
    case (mode_state)
      MODE_LIVE: begin
        ph = now - cf_minlive;
        snap = cf_minlive;
      end
      MODE_DELAYED: begin
        ph = now - cf_delay;
        snap = cf_delay;
      end
      MODE_PAUSED: begin
        spd = '0;
        if (eff > 0 && ph <= now - eff) begin
          ph = now - eff;
          mode_state = MODE_DELAYED;
          spd = SPEED_ONE;
          snap = eff;
        end
      end
      MODE_ACCEL: begin
        advance = (longint'(t.elapsed) * longint'(cf_accel)) >> 8;
        if (ph < now) ph = sat_sum(ph, advance);
        if (ph >= now) begin
          ph = now;
          mode_state = MODE_LIVE;
          snap = cf_minlive;
        end else begin
          spd = cf_accel;
        end
      end
      MODE_DECEL: begin
        tph = now - eff;
        advance = (longint'(t.elapsed) * longint'(cf_decel)) >> 8;
        if (ph > tph) ph = sat_sum(ph, advance);
        if (ph <= tph) begin
          ph = tph;
          mode_state = MODE_DELAYED;
          snap = eff;
        end else begin
          spd = cf_decel;
        end
      end
      default: begin
        d = dist_state;
        if (cf_play <= SPEED_ONE)
          d = d + ((longint'(SPEED_ONE - cf_play) * longint'(t.elapsed)) >> 8);
        else
          d = d - ((longint'(cf_play - SPEED_ONE) * longint'(t.elapsed)) >> 8);
        if (d < cf_minlive) d = cf_minlive;
        if (d > dist_cap) d = dist_cap;
        dist_state = d;
        ph = now - d;
        spd = cf_play;
      end
    endcase
    if (ph > now) ph = now;
    if (depth > 0) oldest = now - depth;
    else oldest = now - longint'({24'd0, NO_DEPTH_SPAN_NS});
    if (ph < oldest) ph = oldest;
    if (ph < 0) ph = 0;
    ph_state = ph;
    f.playhead = ph[62:0];
    f.speed = spd;
    f.snap = (snap < 0) ? SNAP_FREE : snap[40:0];
    f.mode = mode_state;
    expected_frames.push_back(f);
  endfunction

  // Sender: holds each transaction until taken; idles at random outside one stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_ticks.size() != 0 &&
          ((ticks_taken >= 300 && ticks_taken < 450) || $urandom_range(0, 99) >= 36)) begin
        drive_tick = pending_ticks.pop_front();
        in_now_ns <= drive_tick.now;
        in_elapsed_ns <= drive_tick.elapsed;
        in_seek_ns <= drive_tick.seek;
        in_buffered_ns <= drive_tick.buffered;
        in_mode_write <= drive_tick.mode_write;
        in_new_mode <= drive_tick.new_mode;
        in_distance_write <= drive_tick.distance_write;
        in_start_distance_ns <= drive_tick.start_dist;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off early on, and a stretch with none.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = 50;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_seen >= 300 && results_seen < 450) ||
                   $urandom_range(0, 99) >= 36;
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        $error("result with no transaction pending: frame_pos_ns %0d", out_frame_pos_ns);
        fails++;
      end else begin
        exp_f = expected_frames.pop_front();
        if (out_frame_pos_ns !== exp_f.playhead) begin
          $error("frame_pos_ns: expected %0d, got %0d", exp_f.playhead, out_frame_pos_ns);
          fails++;
        end
        if (out_snd_rate !== exp_f.speed) begin
          $error("snd_rate: expected %0d, got %0d", exp_f.speed, out_snd_rate);
          fails++;
        end
        if (out_snd_lag_ns !== exp_f.snap) begin
          $error("snd_lag_ns: expected %0d, got %0d", exp_f.snap, out_snd_lag_ns);
          fails++;
        end
        if (out_mode_out !== exp_f.mode) begin
          $error("mode_out: expected %0d, got %0d", exp_f.mode, out_mode_out);
          fails++;
        end
        mode_hits[exp_f.mode]++;
      end
    end
    if (in_valid && in_ready === 1'b1) begin
      ticks_taken++;
      predict_frame({in_now_ns, in_elapsed_ns, in_seek_ns, in_buffered_ns, in_mode_write,
                     in_new_mode, in_distance_write, in_start_distance_ns});
    end
    in_fire <= in_valid && in_ready === 1'b1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE:       cf_enable = val[0];
      CFG_TARGET_DELAY: cf_delay = longint'({24'd0, val});
      CFG_MIN_LIVE:     cf_minlive = longint'({34'd0, val[29:0]});
      CFG_ACCEL_SPEED:  cf_accel = val[15:0];
      CFG_DECEL_SPEED:  cf_decel = val[15:0];
      CFG_PLAY_SPEED:   cf_play = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_speeds(input longint dly, input longint live, input logic [15:0] acc,
                            input logic [15:0] dec, input logic [15:0] ply);
    write_reg(CFG_TARGET_DELAY, dly[39:0]);
    write_reg(CFG_MIN_LIVE, live[39:0]);
    write_reg(CFG_ACCEL_SPEED, {24'd0, acc});
    write_reg(CFG_DECEL_SPEED, {24'd0, dec});
    write_reg(CFG_PLAY_SPEED, {24'd0, ply});
    settings_used++;
  endtask

  task automatic push_tick(input logic [62:0] now, input logic [31:0] el,
                           input logic signed [40:0] sk, input logic [39:0] depth,
                           input logic mw, input logic [2:0] nm, input logic dw,
                           input logic [39:0] sd);
    pending_ticks.push_back({now, el, sk, depth, mw, nm, dw, sd});
  endtask

  // Mostly time-coherent ticks with occasional commands; the rest is raw noise.
  task automatic queue_ticks(input int count);
    tick_t t;
    int pick;
    longint sk;
    repeat (count) begin
      t.now = 63'({$urandom, $urandom});
      t.elapsed = $urandom;
      t.seek = 41'({$urandom, $urandom});
      t.buffered = 40'({$urandom, $urandom});
      t.mode_write = 1'($urandom);
      t.new_mode = 3'($urandom);
      t.distance_write = 1'($urandom);
      t.start_dist = 40'({$urandom, $urandom});
      if ($urandom_range(0, 99) >= 10) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) t.elapsed = $urandom_range(1_000_000, 250_000_000);
        else if (pick < 95) t.elapsed = $urandom_range(0, 1_000_000);
        gen_now = gen_now + longint'(t.elapsed);
        t.now = gen_now[62:0];
        pick = $urandom_range(0, 99);
        if (pick < 30) t.buffered = '0;
        else if (pick < 70) t.buffered = 40'($urandom_range(0, 400)) * 40'd25_000_000;
        pick = $urandom_range(0, 99);
        sk = longint'($urandom_range(0, 6000)) * MSEC - 3 * SEC;
        if (pick < 88) t.seek = '0;
        else if (pick < 96) t.seek = sk[40:0];
        t.mode_write = $urandom_range(0, 99) < 5;
        t.distance_write = $urandom_range(0, 99) < 4;
        if ($urandom_range(0, 9) < 7) t.start_dist = 40'($urandom_range(0, 8000)) * 40'd1_000_000;
      end
      pending_ticks.push_back(t);
    end
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: commands in these ticks must be ignored.
    queue_ticks(3);
    settle();

    write_reg(CFG_ENABLE, 40'd1);
    set_speeds(2 * SEC, 50 * MSEC, 16'd512, 16'd128, 16'd192);
    push_tick(63'(20 * SEC), 32'd16_666_667, '0, '0, 1'b1, MODE_ACCEL, 1'b0, '0);
    push_tick(63'(20 * SEC + 100 * MSEC), 32'd100_000_000, '0, '0, 1'b1, MODE_DELAYED, 1'b0, '0);
    push_tick(63'(20 * SEC + 200 * MSEC), 32'd100_000_000, '0, 40'(5 * SEC), 1'b1, MODE_LIVE,
              1'b0, '0);
    push_tick(63'(20 * SEC + 300 * MSEC), 32'd100_000_000, '0, 40'(5 * SEC), 1'b1,
              MODE_PAUSED, 1'b0, '0);
    push_tick(63'(21 * SEC + 300 * MSEC), 32'(SEC), '0, 40'(5 * SEC), 1'b0, '0, 1'b0, '0);
    push_tick(63'(22 * SEC + 800 * MSEC), 32'(1500 * MSEC), '0, 40'(5 * SEC), 1'b0, '0,
              1'b0, '0);
    push_tick(63'(22 * SEC + 900 * MSEC), 32'd100_000_000, 41'(-SEC), 40'(5 * SEC), 1'b1,
              MODE_ACCEL, 1'b0, '0);
    push_tick(63'(23 * SEC), 32'd100_000_000, '0, 40'(5 * SEC), 1'b1, MODE_RSVD6, 1'b0, '0);
    push_tick(63'(23 * SEC + 100 * MSEC), 32'd100_000_000, '0, 40'(5 * SEC), 1'b1,
              MODE_RSVD7, 1'b0, '0);
    push_tick(63'(23 * SEC + 200 * MSEC), 32'd100_000_000, '0, 40'(SEC), 1'b1, MODE_DECEL,
              1'b0, '0);
    push_tick(63'(23 * SEC + 300 * MSEC), 32'd100_000_000, '0, '0, 1'b1, MODE_PLAY, 1'b1,
              40'(3 * SEC));
    push_tick(63'(23 * SEC + 400 * MSEC), 32'd100_000_000, '0, '0, 1'b0, '0, 1'b1, DIST_MAX);
    push_tick(63'(30 * SEC), 32'hFFFF_FFFF, '0, 40'hFF_FFFF_FFFF, 1'b0, '0, 1'b1,
              40'(2 * SEC));
    push_tick(63'(30 * SEC + 100 * MSEC), 32'd100_000_000, SEEK_MAX, '0, 1'b1, MODE_PAUSED,
              1'b0, '0);
    push_tick(63'(30 * SEC + 200 * MSEC), 32'd100_000_000, SEEK_MIN, '0, 1'b0, '0, 1'b0, '0);
    push_tick('0, '0, '0, '0, 1'b1, MODE_DELAYED, 1'b0, '0);
    push_tick(63'(SEC), 32'd100_000_000, '0, '0, 1'b0, '0, 1'b0, '0);
    push_tick(NOW_MAX, 32'd100_000_000, '0, '0, 1'b1, MODE_LIVE, 1'b0, '0);
    push_tick(NOW_MAX, '0, SEEK_MAX, '0, 1'b1, MODE_PAUSED, 1'b0, '0);
    push_tick(NOW_MAX, '0, '0, '0, 1'b1, MODE_LIVE, 1'b0, '0);
    push_tick(NOW_MAX, 32'hFFFF_FFFF, '0, '0, 1'b1, MODE_ACCEL, 1'b0, '0);
    push_tick(NOW_MAX, 32'hFFFF_FFFF, '0, '0, 1'b1, MODE_DECEL, 1'b0, '0);
    push_tick(63'(40 * SEC), '0, '0, '0, 1'b1, MODE_PLAY, 1'b1, '0);
    push_tick(63'(40 * SEC + 100 * MSEC), 32'd50_000_000, '0, 40'(3 * SEC), 1'b1, MODE_LIVE,
              1'b0, '0);
    queue_ticks(330);
    settle();

    set_speeds(64'hFF_FFFF_FFFF, 64'h3FFF_FFFF, 16'hFFFF, 16'h0000, 16'h0000);
    queue_ticks(220);
    settle();

    set_speeds(0, 0, 16'h0000, 16'hFFFF, 16'hFFFF);
    queue_ticks(220);
    settle();

    write_reg(CFG_ENABLE, 40'd0);
    queue_ticks(6);
    settle();
    write_reg(CFG_ENABLE, 40'd1);
    set_speeds(longint'($urandom_range(0, 2000)) * 2 * MSEC,
               longint'($urandom_range(0, 32'h3FFF_FFFF)),
               16'($urandom_range(256, 1024)), 16'($urandom_range(0, 255)),
               16'($urandom_range(0, 1024)));
    queue_ticks(250);
    settle();

    $display("summary: %0d ticks accepted (%0d dropped while disabled), %0d results checked,",
             ticks_taken, ticks_dropped, results_seen);
    $display("summary: %0d register settings; by mode: live %0d, delayed %0d, paused %0d,",
             settings_used, mode_hits[0], mode_hits[1], mode_hits[2]);
    $display("summary: accel %0d, decel %0d, play %0d",
             mode_hits[3], mode_hits[4], mode_hits[5]);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
